// ===== hdl/g2c_pkg.sv =====
// Shared constants, types and arithmetic helpers for the grid-to-surface mapper.
package g2c_pkg;

  localparam int unsigned ANGLE_BITS = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 31;

  // long division: numerator width, bits retired per stage, stage count
  localparam int unsigned DIV_W      = 44;
  localparam int unsigned DIV_STEP   = 4;
  localparam int unsigned DIV_STAGES = DIV_W / DIV_STEP;
  localparam int unsigned DEN_W      = 12;

  // sine unit: four multiply stages, four lanes (sin az, cos az, sin pol, cos pol)
  localparam int unsigned SIN_STAGES = 4;
  localparam int unsigned SIN_LANES  = 4;
  localparam int unsigned LANE_SAZ   = 0;
  localparam int unsigned LANE_CAZ   = 1;
  localparam int unsigned LANE_SPOL  = 2;
  localparam int unsigned LANE_CPOL  = 3;

  localparam logic [ANGLE_BITS-1:0] QUARTER_TURN = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;
  localparam logic [30:0] SIN_A   = 31'd1686629713;
  localparam logic [30:0] SIN_B   = 31'd688904866;
  localparam logic [30:0] SIN_C   = 31'd76016977;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE   = 3'd0,
    REG_COLS   = 3'd1,
    REG_ROWS   = 3'd2,
    REG_RADIUS = 3'd3,
    REG_WALL   = 3'd4,
    REG_HEIGHT = 3'd5,
    REG_SWEEP  = 3'd6,
    REG_POLAR  = 3'd7
  } g2c_reg_e;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_ANGLE = 2'd1,
    ERR_SIZE  = 2'd2,
    ERR_GRID  = 2'd3
  } g2c_err_e;

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [DIV_W-1:0] nq;   // numerator bits shift out the top, quotient bits in the bottom
  } g2c_dlane_t;

  typedef struct packed {
    logic [1:0]  quad;
    logic [30:0] x;
    logic [30:0] x2;
    logic [30:0] acc;
  } g2c_slane_t;

  typedef struct packed {
    logic signed [31:0] rad;
    logic [30:0]        py;
  } g2c_side_t;

  // one restoring division step
  function automatic g2c_dlane_t g2c_dstep(input g2c_dlane_t l, input logic [DEN_W-1:0] d);
    logic [DEN_W:0] t;
    g2c_dlane_t     o;
    t = {l.rem, l.nq[DIV_W-1]};
    if (t >= {1'b0, d}) begin
      o.rem = DEN_W'(t - {1'b0, d});
      o.nq  = {l.nq[DIV_W-2:0], 1'b1};
    end else begin
      o.rem = t[DEN_W-1:0];
      o.nq  = {l.nq[DIV_W-2:0], 1'b0};
    end
    return o;
  endfunction

  // fold a phase into quadrant and Q30 fraction of a quarter turn
  function automatic g2c_slane_t g2c_sin_prep(input logic [ANGLE_BITS-1:0] phase);
    g2c_slane_t o;
    o.quad = phase[ANGLE_BITS-1 -: 2];
    o.x    = 31'(phase[ANGLE_BITS-3:0]) << (32 - ANGLE_BITS);
    if (o.quad[0]) begin
      o.x = Q30_ONE - o.x;
    end
    o.x2  = '0;
    o.acc = '0;
    return o;
  endfunction

  // polynomial step k; each step holds one multiply
  function automatic g2c_slane_t g2c_sin_step(input int unsigned k, input g2c_slane_t l);
    logic [61:0] p;
    g2c_slane_t  o;
    o = l;
    p = '0;
    case (k)
      0: begin
        p    = l.x * l.x;
        o.x2 = p[60:30];
      end
      1: begin
        p     = SIN_C * l.x2;
        o.acc = SIN_B - p[60:30];
      end
      2: begin
        p     = l.acc * l.x2;
        o.acc = SIN_A - p[60:30];
      end
      default: begin
        p     = l.acc * l.x;
        o.acc = p[60:30];
      end
    endcase
    return o;
  endfunction

  function automatic logic signed [31:0] g2c_sin_out(input g2c_slane_t l);
    logic [31:0] m;
    m = {1'b0, l.acc};
    return l.quad[1] ? $signed(-m) : $signed(m);
  endfunction

  // length times Q30 factor, rounded to nearest, ties away from zero
  function automatic logic signed [33:0] g2c_mul_q30(input logic signed [33:0] len,
                                                    input logic signed [31:0] f);
    logic        neg;
    logic [33:0] a;
    logic [31:0] b;
    logic [65:0] p;
    logic [33:0] m;
    neg = len[33] ^ f[31];
    a   = len[33] ? 34'(-len) : 34'(len);
    b   = f[31] ? 32'(-f) : 32'(f);
    p   = a * b;
    p   = p + (66'd1 << 29);
    m   = p[63:30];
    return neg ? $signed(-m) : $signed(m);
  endfunction

endpackage

// ===== hdl/grid_to_curved_surface_mapper.sv =====
// Top level: maps grid vertices onto a cylinder or hemisphere.
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+------------------------------------------
//  input    | in_valid_i / in_ready_o      | column_i, row_i, layer_i
//  output   | out_valid_o / out_ready_i    | pos_x_o, pos_y_o, pos_z_o, error_code_o
//  config   | cfg_we_i (no wait)           | cfg_idx_i, cfg_wdata_i
//
// One vertex per cycle while out_ready_i does not stall the pipeline; stages: 1 setup, 11 divider, 4 sine, 2 multiply.
// The divider stage count is set by the 44-bit long division at four bits per stage.
// Reset clears the valid bits and loads the register defaults; no clearing pass.
// Each stage moves on when its successor is free, so bubbles collapse under a stall.
module grid_to_curved_surface_mapper (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [g2c_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [g2c_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [9:0]                          column_i,
  input  logic [9:0]                          row_i,
  input  logic                                layer_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [31:0]                  pos_x_o,
  output logic signed [31:0]                  pos_y_o,
  output logic signed [31:0]                  pos_z_o,
  output logic [1:0]                          error_code_o
);
  import g2c_pkg::*;

  logic        mode_q;
  logic [10:0] cols_q, rows_q;
  logic [30:0] radius_q, wall_q, height_q;
  logic [16:0] sweep_q;
  logic [15:0] polar_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b0;
      cols_q   <= 11'd2;
      rows_q   <= 11'd2;
      radius_q <= 31'd65536;
      wall_q   <= 31'd0;
      height_q <= 31'd65536;
      sweep_q  <= 17'd65536;
      polar_q  <= 16'd16384;
    end else if (cfg_we_i) begin
      case (g2c_reg_e'(cfg_idx_i))
        REG_MODE:   mode_q   <= cfg_wdata_i[0];
        REG_COLS:   cols_q   <= cfg_wdata_i[10:0];
        REG_ROWS:   rows_q   <= cfg_wdata_i[10:0];
        REG_RADIUS: radius_q <= cfg_wdata_i;
        REG_WALL:   wall_q   <= cfg_wdata_i;
        REG_HEIGHT: height_q <= cfg_wdata_i;
        REG_SWEEP:  sweep_q  <= cfg_wdata_i[16:0];
        REG_POLAR:  polar_q  <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // error depends on configuration only
  g2c_err_e err;
  always_comb begin
    if (mode_q ? (sweep_q[16] || polar_q[15]) : (sweep_q[16] && (sweep_q[15:0] != '0))) begin
      err = ERR_ANGLE;
    end else if (radius_q == '0 || (!mode_q && height_q == '0)) begin
      err = ERR_SIZE;
    end else if (cols_q < 11'd2 || rows_q < 11'd2) begin
      err = ERR_GRID;
    end else begin
      err = ERR_OK;
    end
  end

  logic [10:0] cden, rden;
  assign cden = cols_q - 11'd1;
  assign rden = rows_q - 11'd1;

  // ---- setup stage: saturate indices, form numerators and radius
  logic              en_s1, s1_v_q, div_ready;
  logic [DIV_W-1:0]  num_c_q, num_r_q, num_c_d, num_r_d;
  logic signed [31:0] rad_q, rad_d;
  logic [10:0]       col_sat, row_sat;
  logic [27:0]       prod_c;
  logic [41:0]       prod_r;
  logic [30:0]       span_r;

  always_comb begin
    col_sat = ({1'b0, column_i} > cden) ? cden : {1'b0, column_i};
    row_sat = ({1'b0, row_i} > rden) ? rden : {1'b0, row_i};
    span_r  = mode_q ? {15'b0, polar_q} : height_q;
    prod_c  = sweep_q * col_sat;
    prod_r  = span_r * row_sat;
    num_c_d = {15'b0, prod_c, 1'b0} + {33'b0, cden};
    num_r_d = {1'b0, prod_r, 1'b0} + {33'b0, rden};
    rad_d   = $signed({1'b0, radius_q}) - $signed({1'b0, (layer_i ? wall_q : 31'd0)});
  end

  assign en_s1      = ~s1_v_q | div_ready;
  assign in_ready_o = en_s1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en_s1) begin
      s1_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_s1) begin
      num_c_q <= num_c_d;
      num_r_q <= num_r_d;
      rad_q   <= rad_d;
    end
  end

  // ---- fractions
  logic              div_v, sin_ready;
  logic [DIV_W-1:0]  quo_c, quo_r;
  logic signed [31:0] div_rad;

  g2c_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_v_q),
    .ready_o (div_ready),
    .num_c_i (num_c_q),
    .num_r_i (num_r_q),
    .den_c_i ({cden, 1'b0}),
    .den_r_i ({rden, 1'b0}),
    .rad_i   (rad_q),
    .valid_o (div_v),
    .ready_i (sin_ready),
    .quo_c_o (quo_c),
    .quo_r_o (quo_r),
    .rad_o   (div_rad)
  );

  // ---- trig
  logic               sin_v, en_m1;
  logic signed [31:0] sin_az, cos_az, sin_pol, cos_pol;
  g2c_side_t          side_in, side_out;

  assign side_in = '{rad: div_rad, py: quo_r[30:0]};

  g2c_sin u_sin (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (div_v),
    .ready_o   (sin_ready),
    .az_i      (quo_c[ANGLE_BITS-1:0]),
    .pol_i     (quo_r[ANGLE_BITS-1:0]),
    .side_i    (side_in),
    .valid_o   (sin_v),
    .ready_i   (en_m1),
    .sin_az_o  (sin_az),
    .cos_az_o  (cos_az),
    .sin_pol_o (sin_pol),
    .cos_pol_o (cos_pol),
    .side_o    (side_out)
  );

  // ---- first multiply: radius times trig
  logic               m1_v_q, en_out, out_v_q;
  logic signed [33:0] a_q, b_q, c_q;
  logic signed [31:0] sp_q;
  logic [30:0]        py_q;

  assign en_m1 = ~m1_v_q | en_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_v_q <= 1'b0;
    end else if (en_m1) begin
      m1_v_q <= sin_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_m1) begin
      a_q  <= g2c_mul_q30(34'(side_out.rad), cos_az);
      b_q  <= g2c_mul_q30(34'(side_out.rad), sin_az);
      c_q  <= g2c_mul_q30(34'(side_out.rad), cos_pol);
      sp_q <= sin_pol;
      py_q <= side_out.py;
    end
  end

  // ---- second multiply (hemisphere) and output register
  logic signed [31:0] px_d, py_d, pz_d;
  logic signed [33:0] hx, hz;

  always_comb begin
    hx = g2c_mul_q30(a_q, sp_q);
    hz = g2c_mul_q30(b_q, sp_q);
    if (err != ERR_OK) begin
      px_d = '0;
      py_d = '0;
      pz_d = '0;
    end else if (mode_q) begin
      px_d = hx[31:0];
      py_d = c_q[31:0];
      pz_d = hz[31:0];
    end else begin
      px_d = a_q[31:0];
      py_d = $signed({1'b0, py_q});
      pz_d = b_q[31:0];
    end
  end

  assign en_out = ~out_v_q | out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en_out) begin
      out_v_q <= m1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_out) begin
      pos_x_o      <= px_d;
      pos_y_o      <= py_d;
      pos_z_o      <= pz_d;
      error_code_o <= err;
    end
  end

  assign out_valid_o = out_v_q;

endmodule

// ===== hdl/g2c_div.sv =====
// Pipelined long divider: column and row fractions, four quotient bits per stage.
module g2c_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic [g2c_pkg::DIV_W-1:0]     num_c_i,
  input  logic [g2c_pkg::DIV_W-1:0]     num_r_i,
  input  logic [g2c_pkg::DEN_W-1:0]     den_c_i,
  input  logic [g2c_pkg::DEN_W-1:0]     den_r_i,
  input  logic signed [31:0]            rad_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic [g2c_pkg::DIV_W-1:0]     quo_c_o,
  output logic [g2c_pkg::DIV_W-1:0]     quo_r_o,
  output logic signed [31:0]            rad_o
);
  import g2c_pkg::*;

  typedef struct packed {
    g2c_dlane_t         c;
    g2c_dlane_t         r;
    logic signed [31:0] rad;
  } g2c_dst_t;

  logic [DIV_STAGES-1:0] v_q;
  logic [DIV_STAGES-1:0] v_in;
  logic [DIV_STAGES:0]   en;
  g2c_dst_t              st_q  [DIV_STAGES];
  g2c_dst_t              st_in [DIV_STAGES];
  g2c_dst_t              st_d  [DIV_STAGES];

  assign en[DIV_STAGES] = ready_i;

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    assign en[k] = ~v_q[k] | en[k+1];

    if (k == 0) begin : g_first
      assign v_in[k]  = valid_i;
      assign st_in[k] = '{c: '{rem: '0, nq: num_c_i}, r: '{rem: '0, nq: num_r_i}, rad: rad_i};
    end else begin : g_next
      assign v_in[k]  = v_q[k-1];
      assign st_in[k] = st_q[k-1];
    end

    always_comb begin
      st_d[k] = st_in[k];
      for (int s = 0; s < DIV_STEP; s++) begin
        st_d[k].c = g2c_dstep(st_d[k].c, den_c_i);
        st_d[k].r = g2c_dstep(st_d[k].r, den_r_i);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en[k]) begin
        v_q[k] <= v_in[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  assign ready_o = en[0];
  assign valid_o = v_q[DIV_STAGES-1];
  assign quo_c_o = st_q[DIV_STAGES-1].c.nq;
  assign quo_r_o = st_q[DIV_STAGES-1].r.nq;
  assign rad_o   = st_q[DIV_STAGES-1].rad;

endmodule

// ===== hdl/g2c_sin.sv =====
// Four-lane pipelined sine/cosine of azimuth and polar phases.
module g2c_sin (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  output logic                               ready_o,
  input  logic [g2c_pkg::ANGLE_BITS-1:0]     az_i,
  input  logic [g2c_pkg::ANGLE_BITS-1:0]     pol_i,
  input  g2c_pkg::g2c_side_t                 side_i,
  output logic                               valid_o,
  input  logic                               ready_i,
  output logic signed [31:0]                 sin_az_o,
  output logic signed [31:0]                 cos_az_o,
  output logic signed [31:0]                 sin_pol_o,
  output logic signed [31:0]                 cos_pol_o,
  output g2c_pkg::g2c_side_t                 side_o
);
  import g2c_pkg::*;

  typedef struct packed {
    g2c_slane_t [SIN_LANES-1:0] lane;
    g2c_side_t                  side;
  } g2c_sst_t;

  logic [SIN_STAGES-1:0] v_q;
  logic [SIN_STAGES-1:0] v_in;
  logic [SIN_STAGES:0]   en;
  g2c_sst_t              st_q  [SIN_STAGES];
  g2c_sst_t              st_in [SIN_STAGES];
  g2c_sst_t              st_d  [SIN_STAGES];
  g2c_sst_t              prep;

  // cosine is the sine a quarter turn on
  always_comb begin
    prep.lane[LANE_SAZ]  = g2c_sin_prep(az_i);
    prep.lane[LANE_CAZ]  = g2c_sin_prep(az_i + QUARTER_TURN);
    prep.lane[LANE_SPOL] = g2c_sin_prep(pol_i);
    prep.lane[LANE_CPOL] = g2c_sin_prep(pol_i + QUARTER_TURN);
    prep.side            = side_i;
  end

  assign en[SIN_STAGES] = ready_i;

  for (genvar k = 0; k < SIN_STAGES; k++) begin : g_stage
    assign en[k] = ~v_q[k] | en[k+1];

    if (k == 0) begin : g_first
      assign v_in[k]  = valid_i;
      assign st_in[k] = prep;
    end else begin : g_next
      assign v_in[k]  = v_q[k-1];
      assign st_in[k] = st_q[k-1];
    end

    always_comb begin
      st_d[k] = st_in[k];
      for (int l = 0; l < SIN_LANES; l++) begin
        st_d[k].lane[l] = g2c_sin_step(k, st_in[k].lane[l]);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en[k]) begin
        v_q[k] <= v_in[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  assign ready_o   = en[0];
  assign valid_o   = v_q[SIN_STAGES-1];
  assign sin_az_o  = g2c_sin_out(st_q[SIN_STAGES-1].lane[LANE_SAZ]);
  assign cos_az_o  = g2c_sin_out(st_q[SIN_STAGES-1].lane[LANE_CAZ]);
  assign sin_pol_o = g2c_sin_out(st_q[SIN_STAGES-1].lane[LANE_SPOL]);
  assign cos_pol_o = g2c_sin_out(st_q[SIN_STAGES-1].lane[LANE_CPOL]);
  assign side_o    = st_q[SIN_STAGES-1].side;

endmodule

// ===== hdl/g2c_checker.sv =====
// Port-level checks for the mapper, bound to the top level.
module g2c_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic signed [31:0] pos_x_i,
  input logic signed [31:0] pos_y_i,
  input logic signed [31:0] pos_z_i,
  input logic [1:0]         error_code_i
);
  import g2c_pkg::*;

  // a flagged result carries no coordinates
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (error_code_i != ERR_OK) |->
      (pos_x_i == '0) && (pos_y_i == '0) && (pos_z_i == '0))
    else $error("error result with nonzero position");

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output request dropped while stalled");

  a_payload_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(pos_x_i) && $stable(pos_y_i) && $stable(pos_z_i) && $stable(error_code_i))
    else $error("output payload changed while stalled");

endmodule

bind grid_to_curved_surface_mapper g2c_checker u_g2c_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .pos_x_i      (pos_x_o),
  .pos_y_i      (pos_y_o),
  .pos_z_i      (pos_z_o),
  .error_code_i (error_code_o)
);
